### rtl/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package rpn_pkg;

  // Field widths of the command and result beats.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STS_W   = 3;
  localparam int unsigned DEPTH_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STS_W-1:0] STS_MISSING = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 3'd2;
  localparam logic [STS_W-1:0] STS_DIVZERO = 3'd3;
  localparam logic [STS_W-1:0] STS_SAT     = 3'd4;

  // Saturation limits of a signed word.
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic                     start;
    logic [CMD_W-1:0]         op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } alu_req_t;

  // Response of the arithmetic unit; done is a one-cycle pulse.
  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] result;
    logic                     divzero;
    logic                     sat;
  } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/rpn_if.sv
// Valid/ready stream interfaces for command beats and result beats.
// Depends on rpn_pkg for the field widths.
`default_nettype none

interface rpn_cmd_if;
  import rpn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rpn_res_if;
  import rpn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] answer;
  logic [STS_W-1:0]         status;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output answer, output status, output depth, input ready);
  modport sink   (input valid, input answer, input status, input depth, output ready);
endinterface

`default_nettype wire

### rtl/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/rpn_alu.sv
// Shared arithmetic unit: saturating add/subtract, fixed-point multiply and a
// restoring divider that produces one quotient bit per cycle. Uses rpn_pkg.
`default_nettype none

module rpn_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t rsp_o
);
  import rpn_pkg::*;

  // Dividend magnitude width and step counter width.
  localparam int unsigned NW = WORD_W + FRAC_BITS;
  localparam int unsigned SW = $clog2(NW + 1);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_FIN  = 2'd3;

  localparam logic [NW-1:0] POS_LIM = NW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h0000_0000_8000_0000);

  logic [1:0]               st_q, st_d;
  logic                     done_q, done_d;
  logic [SW-1:0]            step_q, step_d;
  logic signed [63:0]       prod_q, prod_d;
  logic [WORD_W-1:0]        dvs_q, dvs_d;
  logic [WORD_W-1:0]        rem_q, rem_d;
  logic [NW-1:0]            quo_q, quo_d;
  logic                     neg_q, neg_d;
  logic signed [WORD_W-1:0] res_q, res_d;
  logic                     dz_q, dz_d;
  logic                     sat_q, sat_d;

  logic [WORD_W:0]          sum_add, sum_sub;
  logic [WORD_W-1:0]        mag_a, mag_b;
  logic signed [63:0]       shifted;
  logic                     mul_fits;
  logic [WORD_W:0]          rem_sh, diff;
  logic                     ge;

  // Clamp a 33-bit sum to a word; the top bit of the return value flags saturation.
  function automatic logic [WORD_W:0] sat33(input logic [WORD_W:0] s);
    logic [WORD_W:0] r;
    if (s[WORD_W] != s[WORD_W-1]) begin
      r = {1'b1, (s[WORD_W] ? WORD_MIN : WORD_MAX)};
    end else begin
      r = {1'b0, s[WORD_W-1:0]};
    end
    return r;
  endfunction

  // Operand preparation and one divider step.
  assign sum_add  = {req_i.a[WORD_W-1], req_i.a} + {req_i.b[WORD_W-1], req_i.b};
  assign sum_sub  = {req_i.b[WORD_W-1], req_i.b} - {req_i.a[WORD_W-1], req_i.a};
  assign mag_a    = req_i.a[WORD_W-1] ? -req_i.a : req_i.a;
  assign mag_b    = req_i.b[WORD_W-1] ? -req_i.b : req_i.b;
  assign shifted  = prod_q >>> FRAC_BITS;
  assign mul_fits = (shifted[63:WORD_W-1] == '0) || (shifted[63:WORD_W-1] == '1);
  assign rem_sh   = {rem_q, quo_q[NW-1]};
  assign diff     = rem_sh - {1'b0, dvs_q};
  assign ge       = rem_sh >= {1'b0, dvs_q};

  // Sequencing of the unit.
  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    step_d = step_q;
    prod_d = prod_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    res_d  = res_q;
    dz_d   = dz_q;
    sat_d  = sat_q;
    case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          dz_d  = 1'b0;
          sat_d = 1'b0;
          case (req_i.op)
            CMD_ADD: begin
              {sat_d, res_d} = sat33(sum_add);
              done_d         = 1'b1;
            end
            CMD_SUB: begin
              {sat_d, res_d} = sat33(sum_sub);
              done_d         = 1'b1;
            end
            CMD_MUL: begin
              prod_d = req_i.a * req_i.b;
              st_d   = A_MUL;
            end
            CMD_DIV: begin
              if (req_i.a == '0) begin
                dz_d   = 1'b1;
                res_d  = req_i.b[WORD_W-1] ? WORD_MIN : WORD_MAX;
                done_d = 1'b1;
              end else begin
                dvs_d  = mag_a;
                rem_d  = '0;
                quo_d  = NW'(mag_b) << FRAC_BITS;
                neg_d  = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
                step_d = SW'(NW);
                st_d   = A_DIV;
              end
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        if (mul_fits) begin
          res_d = shifted[WORD_W-1:0];
        end else begin
          sat_d = 1'b1;
          res_d = shifted[63] ? WORD_MIN : WORD_MAX;
        end
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      A_DIV: begin
        rem_d  = ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        quo_d  = {quo_q[NW-2:0], ge};
        step_d = step_q - SW'(1);
        if (step_q == SW'(1)) begin
          st_d = A_FIN;
        end
      end
      A_FIN: begin
        // Sign the truncated quotient and clamp it to the word range.
        if (!neg_q && (quo_q > POS_LIM)) begin
          sat_d = 1'b1;
          res_d = WORD_MAX;
        end else if (neg_q && (quo_q > NEG_LIM)) begin
          sat_d = 1'b1;
          res_d = WORD_MIN;
        end else if (neg_q) begin
          res_d = -quo_q[WORD_W-1:0];
        end else begin
          res_d = quo_q[WORD_W-1:0];
        end
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      default: begin
        st_d = A_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    dz_q   <= dz_d;
    sat_q  <= sat_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.result  = res_q;
  assign rsp_o.divzero = dz_q;
  assign rsp_o.sat     = sat_q;

endmodule

`default_nettype wire

### rtl/rpn_stack_calculator_core.sv
// RPN stack calculator: operand stack in RAM, one shared arithmetic unit.
// A push passes through the execute and emit states; an arithmetic command pops
// its operands, runs the shared arithmetic unit, pushes the answer and then emits.
// One command at a time; the next is taken in the cycle after the result registers.
// Reset clears the stack count and the handshakes; stack RAM contents are not cleared.
`default_nettype none

module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpn_cmd_if.sink     cmd_i,
  rpn_res_if.source   res_o
);
  import rpn_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POPA = 3'd2;
  localparam logic [2:0] S_POPB = 3'd3;
  localparam logic [2:0] S_GETB = 3'd4;
  localparam logic [2:0] S_ALU  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]               st_q, st_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     ovld_q, ovld_d;
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic signed [WORD_W-1:0] val_q, val_d;
  logic signed [WORD_W-1:0] a_q, a_d;
  logic signed [WORD_W-1:0] b_q, b_d;
  logic                     amem_q, amem_d;
  logic                     bmem_q, bmem_d;
  logic                     miss_q, miss_d;
  logic signed [WORD_W-1:0] ans_q, ans_d;
  logic [STS_W-1:0]         sts_q, sts_d;
  logic signed [WORD_W-1:0] oans_q, oans_d;
  logic [STS_W-1:0]         osts_q, osts_d;
  logic [DEPTH_W-1:0]       odep_q, odep_d;

  logic [CW-1:0]            cnt_m1;
  logic                     ram_we, ram_re;
  logic [WORD_W-1:0]        ram_wdata, ram_rdata;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  alu_req_t                 alu_req;
  alu_rsp_t                 alu_rsp;

  assign cnt_m1 = cnt_q - CW'(1);

  // Stack storage.
  rpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared arithmetic unit.
  rpn_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Command sequencer.
  always_comb begin
    st_d          = st_q;
    cnt_d         = cnt_q;
    ovld_d        = ovld_q;
    cmd_d         = cmd_q;
    val_d         = val_q;
    a_d           = a_q;
    b_d           = b_q;
    amem_d        = amem_q;
    bmem_d        = bmem_q;
    miss_d        = miss_q;
    ans_d         = ans_q;
    sts_d         = sts_q;
    oans_d        = oans_q;
    osts_d        = osts_q;
    odep_d        = odep_q;
    ram_we        = 1'b0;
    ram_waddr     = cnt_q[AW-1:0];
    ram_wdata     = val_q;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = cmd_q;
    alu_req.a     = a_q;
    alu_req.b     = b_q;

    // The output beat leaves when the sink takes it.
    if (ovld_q && res_o.ready) begin
      ovld_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = cmd_i.cmd;
          val_d = cmd_i.value;
          if (cmd_i.cmd == CMD_ADD || cmd_i.cmd == CMD_SUB ||
              cmd_i.cmd == CMD_MUL || cmd_i.cmd == CMD_DIV) begin
            st_d = S_POPA;
          end else begin
            st_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // Push, or an unused code that leaves the stack alone.
        if (cmd_q == CMD_PUSH) begin
          ans_d = val_q;
          if (cnt_q < CW'(STACK_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
            sts_d  = STS_OK;
          end else begin
            sts_d = STS_FULL;
          end
        end else begin
          ans_d = '0;
          sts_d = STS_OK;
        end
        st_d = S_EMIT;
      end
      S_POPA: begin
        a_d    = '0;
        miss_d = 1'b0;
        if (cnt_q != '0) begin
          ram_re = 1'b1;
          cnt_d  = cnt_m1;
          amem_d = 1'b1;
        end else begin
          amem_d = 1'b0;
          miss_d = 1'b1;
        end
        st_d = S_POPB;
      end
      S_POPB: begin
        if (amem_q) begin
          a_d = ram_rdata;
        end
        b_d = '0;
        if (cnt_q != '0) begin
          ram_re = 1'b1;
          cnt_d  = cnt_m1;
          bmem_d = 1'b1;
        end else begin
          bmem_d = 1'b0;
          miss_d = 1'b1;
        end
        st_d = S_GETB;
      end
      S_GETB: begin
        if (bmem_q) begin
          b_d = ram_rdata;
        end
        st_d = S_ALU;
      end
      S_ALU: begin
        alu_req.start = 1'b1;
        st_d          = S_WAIT;
      end
      S_WAIT: begin
        // Push the result; two pops always leave room for it.
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = alu_rsp.result;
          cnt_d     = cnt_q + CW'(1);
          ans_d     = alu_rsp.result;
          if (miss_q) begin
            sts_d = STS_MISSING;
          end else if (alu_rsp.divzero) begin
            sts_d = STS_DIVZERO;
          end else if (alu_rsp.sat) begin
            sts_d = STS_SAT;
          end else begin
            sts_d = STS_OK;
          end
          st_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ovld_q || res_o.ready) begin
          oans_d = ans_q;
          osts_d = sts_q;
          odep_d = DEPTH_W'(cnt_q);
          ovld_d = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    a_q    <= a_d;
    b_q    <= b_d;
    amem_q <= amem_d;
    bmem_q <= bmem_d;
    miss_q <= miss_d;
    ans_q  <= ans_d;
    sts_q  <= sts_d;
    oans_q <= oans_d;
    osts_q <= osts_d;
    odep_q <= odep_d;
  end

  assign cmd_i.ready  = (st_q == S_IDLE);
  assign res_o.valid  = ovld_q;
  assign res_o.answer = oans_q;
  assign res_o.status = osts_q;
  assign res_o.depth  = odep_q;

  // The stack count never passes the stack size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond stack size");

  // A full-stack result beat reports a full stack.
  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STS_FULL) |-> res_o.depth == DEPTH_W'(STACK_DEPTH))
    else $error("stack full reported with partial depth");

  // The arithmetic unit only finishes while the sequencer waits for it.
  a_alu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> st_q == S_WAIT)
    else $error("arithmetic result arrived outside the wait state");

  // A push onto a full stack leaves the count unchanged.
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EXEC && cmd_q == CMD_PUSH && cnt_q == CW'(STACK_DEPTH)) |=> $stable(cnt_q))
    else $error("push onto a full stack changed the count");

endmodule

`default_nettype wire
